@@ src/hsc_pkg.sv @@
// ---------------------------------------------------------------------------
// hsc_pkg: shared types and constants for the heat station controller
// Field widths, menu codes, register indexes, timing limits and handshake
// structs used by the control sequencer and the remainder unit.
// ---------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    // field widths
    localparam int COUNT_W = 10;
    localparam int TIME_W  = 32;
    localparam int TEMP_W  = 11;
    localparam int SET_W   = 11;
    localparam int AIR_W   = 10;
    localparam int DUTY_W  = 16;
    localparam int MIN_W   = 10;
    localparam int OFS_W   = 7;
    localparam int STEP_W  = 6;
    localparam int MENU_W  = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    // dividend of the quantizer: count plus menu minimum, one bit of headroom
    localparam int DIV_W  = COUNT_W + 1;
    localparam int ITER_W = $clog2(DIV_W + 1);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;

    // button timing in ms
    localparam logic [TIME_W-1:0] SHORT_MS = 32'd50;
    localparam logic [TIME_W-1:0] LONG_MS  = 32'd400;

    // airflow levels in percent
    localparam logic [AIR_W-1:0] PCT_FULL = 10'd100;
    localparam logic [AIR_W-1:0] AIR_RUN  = 10'd50;
    localparam logic [AIR_W-1:0] AIR_COOL = 10'd100;
    localparam logic [AIR_W-1:0] AIR_STOP = 10'd0;

    // cool-down thresholds above gun_min
    localparam int COOL_ON_DELTA  = 30;
    localparam int COOL_OFF_DELTA = 20;

    localparam logic [SET_W:0] SET_MAX = 12'd2047;

    // menu codes
    localparam logic [MENU_W-1:0] MENU_IRON = 2'd0;
    localparam logic [MENU_W-1:0] MENU_GUN  = 2'd1;
    localparam logic [MENU_W-1:0] MENU_AIR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IRON_MIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRON_MAX = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRON_OFS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUN_MIN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GUN_MAX  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GUN_OFS  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_MIN  = 4'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } seq_state_t;

    // request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } rem_req_t;

    // response from the remainder unit
    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] remainder;
    } rem_rsp_t;

    // 60 * pct as shifts: 64*pct - 4*pct
    function automatic logic [DUTY_W-1:0] duty_of(input logic [AIR_W-1:0] pct);
        logic [DUTY_W-1:0] wide;
        wide = {{(DUTY_W-AIR_W){1'b0}}, pct};
        return (wide << 6) - (wide << 2);
    endfunction

endpackage

`default_nettype wire

@@ src/hsc_rem_unit.sv @@
// ---------------------------------------------------------------------------
// hsc_rem_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; returns dividend mod divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module hsc_rem_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  hsc_pkg::rem_req_t   req,
    output hsc_pkg::rem_rsp_t   rsp
);
    import hsc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DIV_W-1:0]  shift_reg, shift_next;
    logic [STEP_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W:0]   trial, diff;

    // shift one bit in, subtract when it fits
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        iter_next  = iter_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, shift_reg[DIV_W-1]};
        diff       = trial - {1'b0, div_reg};
        if (req.start) begin
            busy_next  = 1'b1;
            iter_next  = ITER_W'(DIV_W);
            shift_next = req.dividend;
            div_next   = req.divisor;
            rem_next   = '0;
        end else if (busy_reg) begin
            shift_next = {shift_reg[DIV_W-2:0], 1'b0};
            // partial remainder stays below the divisor, so it fits STEP_W bits
            rem_next   = (trial >= {1'b0, div_reg}) ? diff[STEP_W-1:0]
                                                    : trial[STEP_W-1:0];
            iter_next  = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

@@ src/heat_station_setpoint_and_onoff_control.sv @@
// ---------------------------------------------------------------------------
// heat_station_setpoint_and_onoff_control: setpoint and on/off controller
// Knob quantizing, short/long press handling, iron and gun on/off control
// and the fan cool-down rule, one tick per input beat.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | content
//  s_      | in        | s_tvalid/s_tready  | one tick: knob, button, time, temps
//  m_      | out       | m_tvalid/m_tready  | heater bits, fan duty, setpoints, status
//  cfg_    | in        | cfg_valid/cfg_ready| register index and value
//
//  A tick steps from idle through load to finish, and when the setpoint is
//  quantized it also waits in the divide state for the serial remainder unit.
//  s_tready is high only while the sequencer is idle; cfg_ready is always high.
//  The result register holds a beat while m_tready is low; the next tick is
//  still taken and its result waits until the register is free.
//  Reset (aresetn low, synchronous) restores setpoints, config and control state.
// ---------------------------------------------------------------------------
`default_nettype none

module heat_station_setpoint_and_onoff_control (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // knob_count[9:0], button_level[10], time_ms[42:11], iron_temp[53:43],
    // gun_temp[64:54], zero fill above
    input  wire  [hsc_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // iron_heat[0], gun_heat[1], fan_duty[17:2], iron_target[28:18],
    // gun_target[39:29], air_percent[49:40], menu_sel[51:50],
    // iron_enabled[52], gun_enabled[53], clear_count[54], zero fill above
    output logic [hsc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [hsc_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire  [hsc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import hsc_pkg::*;

    seq_state_t state_reg, state_next;

    // configuration
    logic [MIN_W-1:0]  iron_min_reg, iron_max_reg, gun_min_reg, gun_max_reg;
    logic [OFS_W-1:0]  iron_ofs_reg, gun_ofs_reg, air_min_reg;
    logic [STEP_W-1:0] step_reg;

    // latched tick
    logic [COUNT_W-1:0] knob_reg;
    logic               btn_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [TEMP_W-1:0]  itemp_reg, gtemp_reg;

    // controller state
    logic [MENU_W-1:0]  menu_reg, menu_next;
    logic               iron_on_reg, iron_on_next;
    logic               gun_on_reg, gun_on_next;
    logic               short_reg, short_next;
    logic               long_reg, long_next;
    logic [TIME_W-1:0]  press_reg, press_next;
    logic [COUNT_W-1:0] last_reg, last_next;
    logic               wrap_reg, wrap_next;
    logic [SET_W-1:0]   iron_set_reg, iron_set_next;
    logic [SET_W-1:0]   gun_set_reg, gun_set_next;
    logic [AIR_W-1:0]   air_reg, air_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic               fan_mode_reg, fan_mode_next;
    logic               cool_start_reg, cool_start_next;
    logic               cool_stop_reg, cool_stop_next;

    // per-tick working registers
    logic               quant_reg, quant_next;
    logic               clr_reg, clr_next;
    logic [DIV_W-1:0]   x_reg, x_next;
    logic [DIV_W-1:0]   q_reg, q_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    rem_req_t rreq;
    rem_rsp_t rrsp;

    // working values for the load and finish steps
    logic [COUNT_W-1:0] cnt_eff;
    logic [MIN_W-1:0]   base;
    logic [DIV_W:0]     q_ofs;
    logic [TIME_W-1:0]  elapsed;
    logic               pressed;
    logic               iron_heat, gun_heat;
    logic signed [12:0] itemp_x, gtemp_x, cool_on_lim, cool_off_lim;
    logic               out_free;

    hsc_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rreq),
        .rsp     (rrsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // sequencer and tick evaluation
    always_comb begin
        state_next      = state_reg;
        menu_next       = menu_reg;
        iron_on_next    = iron_on_reg;
        gun_on_next     = gun_on_reg;
        short_next      = short_reg;
        long_next       = long_reg;
        press_next      = press_reg;
        last_next       = last_reg;
        wrap_next       = wrap_reg;
        iron_set_next   = iron_set_reg;
        gun_set_next    = gun_set_reg;
        air_next        = air_reg;
        duty_next       = duty_reg;
        fan_mode_next   = fan_mode_reg;
        cool_start_next = cool_start_reg;
        cool_stop_next  = cool_stop_reg;
        quant_next      = quant_reg;
        clr_next        = clr_reg;
        x_next          = x_reg;
        q_next          = q_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        rreq.start    = 1'b0;
        rreq.dividend = x_reg;
        rreq.divisor  = (step_reg == '0) ? STEP_W'(1) : step_reg;

        cnt_eff = wrap_reg ? '0 : knob_reg;
        unique case (menu_reg)
            MENU_IRON: base = iron_min_reg;
            MENU_GUN:  base = gun_min_reg;
            default:   base = {{(MIN_W-OFS_W){1'b0}}, air_min_reg};
        endcase

        q_ofs     = '0;
        pressed   = !btn_reg;
        elapsed   = time_reg - press_reg;
        iron_heat = 1'b0;
        gun_heat  = 1'b0;
        itemp_x   = {{2{itemp_reg[TEMP_W-1]}}, itemp_reg};
        gtemp_x   = {{2{gtemp_reg[TEMP_W-1]}}, gtemp_reg};
        cool_on_lim  = $signed({3'b000, gun_min_reg}) + 13'sd30;
        cool_off_lim = $signed({3'b000, gun_min_reg}) + 13'sd20;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOAD;
            end

            // pending clear, knob change detect, start the quantizer
            ST_LOAD: begin
                clr_next  = wrap_reg;
                wrap_next = 1'b0;
                x_next    = {1'b0, cnt_eff} + {1'b0, base};
                quant_next = 1'b0;
                if (cnt_eff != last_reg) begin
                    last_next  = cnt_eff;
                    quant_next = (menu_reg == MENU_IRON) || (menu_reg == MENU_GUN) ||
                                 ((menu_reg == MENU_AIR) && gun_on_reg);
                end
                if (quant_next) begin
                    rreq.start    = 1'b1;
                    rreq.dividend = x_next;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_DIV: begin
                if (rrsp.done) begin
                    q_next     = x_reg - {{(DIV_W-STEP_W){1'b0}}, rrsp.remainder};
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    // knob setpoint
                    if (quant_reg) begin
                        unique case (menu_reg)
                            MENU_IRON: begin
                                if (q_reg > {1'b0, iron_max_reg}) wrap_next = 1'b1;
                                q_ofs = {1'b0, q_reg} + {{(DIV_W+1-OFS_W){1'b0}}, iron_ofs_reg};
                                iron_set_next = (q_ofs > SET_MAX) ? SET_MAX[SET_W-1:0]
                                                                  : q_ofs[SET_W-1:0];
                            end
                            MENU_GUN: begin
                                if (q_reg > {1'b0, gun_max_reg}) wrap_next = 1'b1;
                                q_ofs = {1'b0, q_reg} + {{(DIV_W+1-OFS_W){1'b0}}, gun_ofs_reg};
                                gun_set_next = (q_ofs > SET_MAX) ? SET_MAX[SET_W-1:0]
                                                                 : q_ofs[SET_W-1:0];
                            end
                            default: begin
                                if (q_reg > {1'b0, PCT_FULL}) wrap_next = 1'b1;
                                air_next  = q_reg[DIV_W-1] ? '1 : q_reg[AIR_W-1:0];
                                duty_next = duty_of(air_next);
                            end
                        endcase
                    end

                    // button: short and long press
                    if (pressed && !short_reg && (elapsed > SHORT_MS)) begin
                        short_next = 1'b1;
                        long_next  = 1'b0;
                        press_next = time_reg;
                    end else if (pressed && !long_reg && (elapsed > LONG_MS)) begin
                        long_next = 1'b1;
                        if (menu_reg == MENU_IRON) iron_on_next = !iron_on_reg;
                        else if ((menu_reg == MENU_GUN) || (menu_reg == MENU_AIR))
                            gun_on_next = !gun_on_reg;
                    end else if (!pressed && short_reg && (elapsed > SHORT_MS)) begin
                        short_next = 1'b0;
                        press_next = time_reg;
                        if (!long_reg) begin
                            menu_next = (menu_reg == MENU_IRON) ? MENU_GUN :
                                        (menu_reg == MENU_GUN)  ? MENU_AIR : MENU_IRON;
                        end
                    end

                    iron_heat = iron_on_next &&
                                ($signed({2'b00, iron_set_next}) > itemp_x);

                    // fan cool-down rule and gun heater
                    if (!gun_on_next) begin
                        fan_mode_next = 1'b0;
                        if ((gtemp_x > cool_on_lim) && !cool_start_reg) begin
                            cool_start_next = 1'b1;
                            air_next  = AIR_COOL;
                            duty_next = duty_of(AIR_COOL);
                        end
                        if ((gtemp_x < cool_off_lim) && !cool_stop_reg) begin
                            cool_stop_next = 1'b1;
                            air_next  = AIR_STOP;
                            duty_next = duty_of(AIR_STOP);
                        end
                    end else begin
                        cool_start_next = 1'b0;
                        cool_stop_next  = 1'b0;
                        if (!fan_mode_reg) begin
                            fan_mode_next = 1'b1;
                            air_next  = AIR_RUN;
                            duty_next = duty_of(AIR_RUN);
                        end
                        gun_heat = $signed({2'b00, gun_set_next}) > gtemp_x;
                    end

                    m_data_next = {1'b0, clr_reg, gun_on_next, iron_on_next, menu_next,
                                   air_next, gun_set_next, iron_set_next, duty_next,
                                   gun_heat, iron_heat};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iron_min_reg <= 10'd100;
            iron_max_reg <= 10'd450;
            iron_ofs_reg <= 7'd20;
            step_reg     <= 6'd5;
            gun_min_reg  <= 10'd50;
            gun_max_reg  <= 10'd400;
            gun_ofs_reg  <= 7'd0;
            air_min_reg  <= 7'd30;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_IRON_MIN: iron_min_reg <= cfg_data[MIN_W-1:0];
                CFG_IRON_MAX: iron_max_reg <= cfg_data[MIN_W-1:0];
                CFG_IRON_OFS: iron_ofs_reg <= cfg_data[OFS_W-1:0];
                CFG_STEP:     step_reg     <= cfg_data[STEP_W-1:0];
                CFG_GUN_MIN:  gun_min_reg  <= cfg_data[MIN_W-1:0];
                CFG_GUN_MAX:  gun_max_reg  <= cfg_data[MIN_W-1:0];
                CFG_GUN_OFS:  gun_ofs_reg  <= cfg_data[OFS_W-1:0];
                CFG_AIR_MIN:  air_min_reg  <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            knob_reg  <= s_tdata[9:0];
            btn_reg   <= s_tdata[10];
            time_reg  <= s_tdata[42:11];
            itemp_reg <= s_tdata[53:43];
            gtemp_reg <= s_tdata[64:54];
        end
    end

    // controller state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            menu_reg       <= MENU_IRON;
            iron_on_reg    <= 1'b0;
            gun_on_reg     <= 1'b0;
            short_reg      <= 1'b0;
            long_reg       <= 1'b0;
            press_reg      <= '0;
            last_reg       <= '0;
            wrap_reg       <= 1'b0;
            iron_set_reg   <= 11'd320;
            gun_set_reg    <= 11'd150;
            air_reg        <= 10'd50;
            duty_reg       <= '0;
            fan_mode_reg   <= 1'b0;
            cool_start_reg <= 1'b0;
            cool_stop_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            menu_reg       <= menu_next;
            iron_on_reg    <= iron_on_next;
            gun_on_reg     <= gun_on_next;
            short_reg      <= short_next;
            long_reg       <= long_next;
            press_reg      <= press_next;
            last_reg       <= last_next;
            wrap_reg       <= wrap_next;
            iron_set_reg   <= iron_set_next;
            gun_set_reg    <= gun_set_next;
            air_reg        <= air_next;
            duty_reg       <= duty_next;
            fan_mode_reg   <= fan_mode_next;
            cool_start_reg <= cool_start_next;
            cool_stop_reg  <= cool_stop_next;
            m_valid_reg    <= m_valid_next;
        end
        quant_reg  <= quant_next;
        clr_reg    <= clr_next;
        x_reg      <= x_next;
        q_reg      <= q_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire
